@@ hdl/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and transaction types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// b*b needs 2*COEF_WIDTH bits, 4ac and their sum two more
	localparam int DISC_W = 2 * COEF_WIDTH + 2;
	// floor(sqrt) of a DISC_W-bit value
	localparam int ROOT_W = DISC_W / 2;
	// square root remainder stays below 2*root+1
	localparam int SREM_W = ROOT_W + 2;
	// -b takes one bit more than b
	localparam int NB_W   = COEF_WIDTH + 1;
	// -b +- sqrt, signed
	localparam int NUM_W  = ROOT_W + 2;
	localparam int NMAG_W = NUM_W - 1;
	// dividend is |numerator| shifted by the fraction bits
	localparam int DVD_W  = NMAG_W + FRAC_BITS;
	// divisor is 2*|a|
	localparam int DVS_W  = COEF_WIDTH + 1;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] coef_a;
		logic signed [COEF_WIDTH-1:0] coef_b;
		logic signed [COEF_WIDTH-1:0] coef_c;
	} in_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] root_low;
		logic signed [COEF_WIDTH-1:0] root_high;
		logic                         no_real_roots;
		logic                         zero_leading;
		logic                         saturated;
	} out_t;

	// side information that rides along with the dividers
	typedef struct packed {
		logic neg_lo;
		logic neg_hi;
		logic no_real;
		logic zero;
	} side_t;

endpackage
`default_nettype wire

@@ hdl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// One coefficient transaction can be taken every cycle while the output
// register is not stalled.
// The result passes the 33-stage square root pipeline (one root bit per
// stage) and the 50-stage dividers (one quotient bit per stage). The whole
// pipeline advances together; it holds when the output register is full and
// not taken. The square root is floored and the division truncates toward
// zero; flagged cases return zero roots.
module quadratic_root_solver (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire qrs_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output qrs_pkg::out_t      out_data
);
	import qrs_pkg::*;

	typedef struct packed {
		logic [DISC_W-1:0]     x;
		logic [SREM_W-1:0]     rem;
		logic [ROOT_W-1:0]     root;
		logic [NB_W-1:0]       nb;
		logic [COEF_WIDTH-1:0] amag;
		logic                  aneg;
		logic                  no_real;
		logic                  zero;
	} sq_t;

	logic en;

	// global advance: the output register is empty or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: magnitudes and signs
	logic                  v_s1;
	logic [COEF_WIDTH-1:0] amag_s1, bmag_s1, cmag_s1;
	logic                  aneg_s1, cneg_s1;
	logic [NB_W-1:0]       nb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aneg_s1 <= in_data.coef_a[COEF_WIDTH-1];
			cneg_s1 <= in_data.coef_c[COEF_WIDTH-1];
			amag_s1 <= in_data.coef_a[COEF_WIDTH-1] ? -in_data.coef_a : in_data.coef_a;
			bmag_s1 <= in_data.coef_b[COEF_WIDTH-1] ? -in_data.coef_b : in_data.coef_b;
			cmag_s1 <= in_data.coef_c[COEF_WIDTH-1] ? -in_data.coef_c : in_data.coef_c;
			nb_s1   <= -{in_data.coef_b[COEF_WIDTH-1], in_data.coef_b};
		end
	end

	// stage 2: b*b and a*c
	logic                    v_s2;
	logic [2*COEF_WIDTH-1:0] bsq_s2, ac_s2;
	logic [COEF_WIDTH-1:0]   amag_s2;
	logic                    aneg_s2, opp_s2;
	logic [NB_W-1:0]         nb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s2  <= bmag_s1 * bmag_s1;
			ac_s2   <= amag_s1 * cmag_s1;
			amag_s2 <= amag_s1;
			aneg_s2 <= aneg_s1;
			opp_s2  <= aneg_s1 != cneg_s1;
			nb_s2   <= nb_s1;
		end
	end

	// stage 3: discriminant, enters the square root pipeline
	logic [DISC_W-1:0] bsq_w, fac_w, disc_w;
	logic              ac_nz, no_real_w;
	sq_t               sq_s [0:ROOT_W];
	logic              sq_v [0:ROOT_W];

	always_comb begin
		bsq_w     = {2'b00, bsq_s2};
		fac_w     = {ac_s2, 2'b00};
		ac_nz     = ac_s2 != '0;
		no_real_w = 1'b0;
		priority if (opp_s2 && ac_nz) begin
			disc_w = bsq_w + fac_w;
		end else if (bsq_w >= fac_w) begin
			disc_w = bsq_w - fac_w;
		end else begin
			disc_w    = '0;
			no_real_w = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].rem     <= '0;
			sq_s[0].root    <= '0;
			sq_s[0].nb      <= nb_s2;
			sq_s[0].amag    <= amag_s2;
			sq_s[0].aneg    <= aneg_s2;
			sq_s[0].zero    <= amag_s2 == '0;
			sq_s[0].no_real <= no_real_w;
			sq_s[0].x       <= disc_w;
		end
	end

	// square root: one result bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [SREM_W+1:0] r4;
		logic [SREM_W+1:0] trial;
		logic              take;
		logic [SREM_W+1:0] diff;
		sq_t               nxt;

		always_comb begin
			r4       = {sq_s[k].rem, sq_s[k].x[DISC_W-1 -: 2]};
			trial    = {2'b00, sq_s[k].root, 2'b01};
			take     = r4 >= trial;
			diff     = r4 - trial;
			nxt      = sq_s[k];
			nxt.x    = {sq_s[k].x[DISC_W-3:0], 2'b00};
			nxt.rem  = take ? diff[SREM_W-1:0] : r4[SREM_W-1:0];
			nxt.root = {sq_s[k].root[ROOT_W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// stage 4: numerators -b -+ sqrt, divider operands
	sq_t              sq_end;
	logic [NUM_W-1:0] nlo_w, nhi_w;
	logic             v_s4;
	logic [DVD_W-1:0] dvd_lo_s4, dvd_hi_s4;
	logic [DVS_W-1:0] dvs_s4;
	side_t            side_s4;

	always_comb begin
		sq_end = sq_s[ROOT_W];
		nlo_w  = {{(NUM_W-NB_W){sq_end.nb[NB_W-1]}}, sq_end.nb}
			- {{(NUM_W-ROOT_W){1'b0}}, sq_end.root};
		nhi_w  = {{(NUM_W-NB_W){sq_end.nb[NB_W-1]}}, sq_end.nb}
			+ {{(NUM_W-ROOT_W){1'b0}}, sq_end.root};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_lo_s4 <= {(nlo_w[NUM_W-1] ? NMAG_W'(-nlo_w) : nlo_w[NMAG_W-1:0]),
				{FRAC_BITS{1'b0}}};
			dvd_hi_s4 <= {(nhi_w[NUM_W-1] ? NMAG_W'(-nhi_w) : nhi_w[NMAG_W-1:0]),
				{FRAC_BITS{1'b0}}};
			dvs_s4         <= {sq_end.amag, 1'b0};
			side_s4.neg_lo <= nlo_w[NUM_W-1] != sq_end.aneg;
			side_s4.neg_hi <= nhi_w[NUM_W-1] != sq_end.aneg;
			side_s4.no_real <= sq_end.no_real;
			side_s4.zero    <= sq_end.zero;
		end
	end

	// dividers for both roots
	logic [DVD_W-1:0] q_lo, q_hi;

	qrs_div_pipe u_div_lo (
		.clk      (clk),
		.en       (en),
		.dividend (dvd_lo_s4),
		.divisor  (dvs_s4),
		.quotient (q_lo)
	);

	qrs_div_pipe u_div_hi (
		.clk      (clk),
		.en       (en),
		.dividend (dvd_hi_s4),
		.divisor  (dvs_s4),
		.quotient (q_hi)
	);

	// side information delay matching the dividers
	side_t side_s [0:DVD_W];
	logic  side_v [0:DVD_W];

	assign side_s[0] = side_s4;
	assign side_v[0] = v_s4;

	for (genvar k = 0; k < DVD_W; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_v[k+1] <= 1'b0;
			end else if (en) begin
				side_v[k+1] <= side_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// saturation and sign, output register
	side_t                 side_end;
	logic [DVD_W-1:0]      lim_lo, lim_hi;
	logic                  sat_lo, sat_hi, kill;
	logic [COEF_WIDTH-1:0] mag_lo, mag_hi;
	out_t                  res_w;
	out_t                  out_q;
	logic                  out_valid_q;

	always_comb begin
		side_end = side_s[DVD_W];
		lim_lo = (DVD_W'(1) << (COEF_WIDTH-1)) - DVD_W'(!side_end.neg_lo);
		lim_hi = (DVD_W'(1) << (COEF_WIDTH-1)) - DVD_W'(!side_end.neg_hi);
		sat_lo = q_lo > lim_lo;
		sat_hi = q_hi > lim_hi;
		mag_lo = sat_lo ? lim_lo[COEF_WIDTH-1:0] : q_lo[COEF_WIDTH-1:0];
		mag_hi = sat_hi ? lim_hi[COEF_WIDTH-1:0] : q_hi[COEF_WIDTH-1:0];
		kill   = side_end.no_real || side_end.zero;
		res_w.root_low      = kill ? '0 : (side_end.neg_lo ? -mag_lo : mag_lo);
		res_w.root_high     = kill ? '0 : (side_end.neg_hi ? -mag_hi : mag_hi);
		res_w.no_real_roots = side_end.no_real;
		res_w.zero_leading  = side_end.zero;
		res_w.saturated     = !kill && (sat_lo || sat_hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_v[DVD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a zero leading coefficient leaves a discriminant of b*b, never negative
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.no_real_roots && out_data.zero_leading))
		else $error("no_real_roots and zero_leading both set");

	// flagged transactions carry zero roots and no clamp
	a_flagged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.no_real_roots || out_data.zero_leading)
		|-> out_data.root_low == '0 && out_data.root_high == '0 && !out_data.saturated)
		else $error("flagged result has nonzero roots");

	// a stalled output keeps the pipeline frozen
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(side_v[DVD_W]) && $stable(v_s4))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire

@@ hdl/qrs_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [qrs_pkg::DVD_W-1:0]   dividend,
	input  wire logic [qrs_pkg::DVS_W-1:0]   divisor,
	output logic      [qrs_pkg::DVD_W-1:0]   quotient
);
	import qrs_pkg::*;

	// per stage: dividend bits shifting out, quotient bits shifting in
	logic [DVD_W-1:0] num_s [0:DVD_W];
	logic [DVS_W-1:0] rem_s [0:DVD_W];
	logic [DVS_W-1:0] den_s [0:DVD_W];

	assign num_s[0] = dividend;
	assign rem_s[0] = '0;
	assign den_s[0] = divisor;

	// one trial subtraction per stage
	for (genvar k = 0; k < DVD_W; k++) begin : g_step
		logic [DVS_W:0] trial;
		logic [DVS_W:0] diff;
		logic           take;

		always_comb begin
			trial = {rem_s[k], num_s[k][DVD_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			take  = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				num_s[k+1] <= {num_s[k][DVD_W-2:0], take};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quotient = num_s[DVD_W];

endmodule
`default_nettype wire
